// ===== hdl/bip_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bip_pkg
// Shared types and constants of the bitmap ID pool: request and response
// payloads, command and status codes, bitmap geometry, control bundles.
// ----------------------------------------------------------------------------
package bip_pkg;

    // Bitmap geometry
    localparam int POOL_CAPACITY = 1024;
    localparam int MAP_WORDS     = (POOL_CAPACITY + 7) / 8;
    localparam int ADDR_W        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int OFF_W         = ADDR_W + 3;
    localparam int CNT_W         = ($clog2(POOL_CAPACITY + 1) > 11) ?
                                   $clog2(POOL_CAPACITY + 1) : 11;

    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MAP_WORDS - 1);
    localparam logic [7:0]        WORD_FULL = 8'hFF;

    // Command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_BASE_ID  = 1'b0;
    localparam logic CFG_ID_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] target_id;
    } req_t;

    typedef struct packed {
        logic [31:0] result_id;
        logic        is_used;
        logic [1:0]  status;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic rd_scan;
        logic rd_lookup;
        logic fin_alloc;
        logic fin_access;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic rvalid;
        logic word_open;
        logic at_last;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/bip_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bip_ctrl
// Sequencer of the ID pool: accepts a request, runs the bitmap scan or the
// single-word lookup, and tells the datapath when to finish.
// ----------------------------------------------------------------------------
module bip_ctrl
    import bip_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] cmd,
    input  wire dp_stat_t   stat,
    output ctl_cmd_t        ctl,
    output logic            busy
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_LOOKUP = 4'b0100,
        S_APPLY  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   scan_done;

    // Scan ends on the first word with a clear bit, or after the last word.
    assign scan_done = stat.rvalid && (stat.word_open || stat.at_last);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = (cmd == CMD_ALLOC) ? S_SCAN : S_LOOKUP;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    ctl.fin_alloc = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    ctl.rd_scan = 1'b1;
                end
            end
            S_LOOKUP:
            begin
                ctl.rd_lookup = 1'b1;
                state_next    = S_APPLY;
            end
            S_APPLY:
            begin
                ctl.fin_access = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |-> !busy)
        else $error("load issued while busy");

    a_apply_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rd_lookup |=> ctl.fin_access)
        else $error("lookup not followed by apply");

    a_single_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.fin_alloc && ctl.fin_access))
        else $error("two finish commands at once");

endmodule
`default_nettype wire

// ===== hdl/bip_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bip_datapath
// Bitmap memory with per-word valid bits, scan pointer, offset and range
// logic, first-clear-bit search and the registered response.
// ----------------------------------------------------------------------------
module bip_datapath
    import bip_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ctl_cmd_t    ctl,
    input  wire req_t        request,
    input  wire logic [31:0] base_id,
    input  wire logic [10:0] id_count,
    output dp_stat_t         stat,
    output logic             done,
    output rsp_t             response
);

    logic [7:0]        map_mem [MAP_WORDS];
    logic              word_valid_reg [MAP_WORDS];

    logic [1:0]        cmd_reg;
    logic [31:0]       target_reg;
    logic [31:0]       off_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] scan_ptr_reg;
    logic [ADDR_W-1:0] rtag_reg;
    logic [7:0]        mem_q_reg;
    logic              vbit_q_reg;
    logic              rvalid_reg;
    logic              done_reg;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    logic [CNT_W-1:0]  live_count;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rword;
    logic [2:0]        low_bit;
    logic [OFF_W-1:0]  alloc_off;
    logic              fits;
    logic              in_range;
    logic              acc_ok;
    logic [7:0]        bit_mask;
    logic              wr_en;
    logic [7:0]        wr_data;

    // Clamp the configured count to the pool capacity.
    assign live_count = (CNT_W'(id_count) > CNT_W'(POOL_CAPACITY)) ?
                        CNT_W'(POOL_CAPACITY) : CNT_W'(id_count);

    assign rd_en   = ctl.rd_scan || ctl.rd_lookup;
    assign rd_addr = ctl.rd_scan ? scan_ptr_reg : off_reg[3 +: ADDR_W];

    // Words never written read as all free.
    assign rword = vbit_q_reg ? mem_q_reg : 8'h00;

    always_comb
    begin
        low_bit = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!rword[i])
                low_bit = 3'(i);
        end
    end

    assign alloc_off = {rtag_reg, low_bit};
    assign fits      = (rword != WORD_FULL) && (32'(alloc_off) < 32'(count_reg));
    assign in_range  = off_reg < 32'(count_reg);
    assign acc_ok    = in_range && ((cmd_reg == CMD_FREE) || (cmd_reg == CMD_CHECK));
    assign bit_mask  = 8'h01 << off_reg[2:0];

    assign wr_en   = (ctl.fin_alloc && fits) ||
                     (ctl.fin_access && acc_ok && (cmd_reg == CMD_FREE));
    assign wr_data = ctl.fin_alloc ? (rword | (8'h01 << low_bit)) : (rword & ~bit_mask);

    always_comb
    begin
        rsp_next = rsp_reg;
        if (ctl.fin_alloc)
        begin
            rsp_next.is_used   = 1'b0;
            rsp_next.result_id = fits ? (base_id + 32'(alloc_off)) : 32'd0;
            rsp_next.status    = fits ? ST_OK : ST_FULL;
        end
        else if (ctl.fin_access)
        begin
            rsp_next.result_id = target_reg;
            rsp_next.is_used   = acc_ok && (cmd_reg == CMD_CHECK) && |(rword & bit_mask);
            rsp_next.status    = acc_ok ? ST_OK : ST_RANGE;
        end
    end

    assign stat.rvalid    = rvalid_reg;
    assign stat.word_open = (rword != WORD_FULL);
    assign stat.at_last   = (rtag_reg == LAST_WORD);

    // Bitmap memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            map_mem[rtag_reg] <= wr_data;
        if (rd_en)
        begin
            mem_q_reg <= map_mem[rd_addr];
            rtag_reg  <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAP_WORDS; i++)
                word_valid_reg[i] <= 1'b0;
            vbit_q_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                word_valid_reg[rtag_reg] <= 1'b1;
            if (rd_en)
                vbit_q_reg <= word_valid_reg[rd_addr];
        end
    end

    // Request capture and scan pointer.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg      <= request.cmd;
            target_reg   <= request.target_id;
            off_reg      <= request.target_id - base_id;
            count_reg    <= live_count;
            scan_ptr_reg <= '0;
        end
        else if (ctl.rd_scan && (scan_ptr_reg != LAST_WORD))
        begin
            scan_ptr_reg <= scan_ptr_reg + 1'b1;
        end
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            rvalid_reg <= ctl.rd_scan;
            done_reg   <= ctl.fin_alloc || ctl.fin_access;
        end
    end

    assign done     = done_reg;
    assign response = rsp_reg;

    a_no_double_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("response strobe on two adjacent cycles");

    a_full_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (rsp_reg.status == ST_FULL)) |->
        ((rsp_reg.result_id == 32'd0) && !rsp_reg.is_used))
        else $error("pool full response carries an ID");

    a_used_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.is_used) |-> (rsp_reg.status == ST_OK))
        else $error("is_used set on a failed request");

    a_alloc_on_data: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fin_alloc |-> rvalid_reg)
        else $error("allocation finished without read data");

endmodule
`default_nettype wire

// ===== hdl/bitmap_id_pool_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_id_pool_core
// First-fit ID allocator over a bitmap of used IDs in base_id..base_id+n-1.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive request (cmd, target_id) with start high; the
//   request is taken at a clock edge where start is high and busy is low.
//   Busy stays high until the response has been produced.
//   Response channel: done pulses for one cycle with response (result_id,
//   is_used, status) valid in that cycle. The receiver cannot stall, so it
//   must take the response in that cycle.
//   Sequence: allocate scans the bitmap one 8-bit word per cycle through the
//   single read port of the bitmap memory and stops at the first word with a
//   clear bit or at the last word. Free and check touch one word: a lookup
//   read, then an apply step. A new request may be taken at the edge that
//   ends the done cycle.
//   Configuration: cfg_we writes base_id (index 0) or id_count (index 1)
//   at once; write only while idle. Writes do not touch the bitmap.
//   Reset: every ID is free (per-word valid bits clear), base_id is 0 and
//   id_count is 1024; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bitmap_id_pool_core
    import bip_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire req_t        request,
    output logic             done,
    output rsp_t             response,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    logic [31:0] base_id_reg;
    logic [10:0] id_count_reg;
    ctl_cmd_t    ctl;
    dp_stat_t    stat;

    // Hold configuration; registers apply from the next request on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_id_reg  <= 32'd0;
            id_count_reg <= 11'd1024;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BASE_ID:  base_id_reg  <= cfg_wdata;
                CFG_ID_COUNT: id_count_reg <= cfg_wdata[10:0];
                default:      base_id_reg  <= base_id_reg;
            endcase
        end
    end

    // Sequence the request: scan for allocate, lookup and apply otherwise.
    bip_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (request.cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    // Bitmap storage, search and response registers.
    bip_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .request  (request),
        .base_id  (base_id_reg),
        .id_count (id_count_reg),
        .stat     (stat),
        .done     (done),
        .response (response)
    );

endmodule
`default_nettype wire

// ===== sim/tb_bitmap_id_pool_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_id_pool_core
// Self-checking bench for the first-fit bitmap ID pool. A shadow bitmap
// predicts each reply when its request is accepted. Every reply is compared
// field by field against the oldest prediction. Directed requests cover the
// corner cases. Random traffic then fills the pool to exhaustion and churns
// small, wrapped and clamped pools.
// ----------------------------------------------------------------------------
module tb_bitmap_id_pool_core;
    import bip_pkg::*;

    // The package has no name for the unused command code
    localparam logic [1:0] CMD_UNKNOWN   = 2'd3;
    localparam int         BITS_PER_WORD = 8;
    localparam int         MAX_PRINTED   = 100;
    // An allocate scans at most MAP_WORDS words; allow plenty beyond that
    localparam int         DRAIN_LIMIT   = 20 * MAP_WORDS;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        busy;
    req_t        request   = '0;
    logic        done;
    rsp_t        response;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_wdata = '0;

    // Shadow copy of the pool: bitmap plus both configuration registers
    logic [7:0]       shadow_map [MAP_WORDS];
    logic [31:0]      shadow_base;
    logic [CNT_W-1:0] shadow_count;

    // Predicted replies, oldest first
    rsp_t       pending_replies [$];
    logic [1:0] last_status;
    logic       no_idle = 1'b0;

    int error_count = 0;
    int sent_count  = 0;
    int alloc_count = 0;
    int free_count  = 0;
    int check_count = 0;
    int other_count = 0;
    int full_count  = 0;
    int range_count = 0;

    bitmap_id_pool_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .response  (response),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Number of IDs actually managed: the count register clamps at capacity.
    function automatic logic [31:0] live_ids();
        return (shadow_count > POOL_CAPACITY) ? 32'(POOL_CAPACITY) : 32'(shadow_count);
    endfunction

    // Work out the reply to one request and update the shadow bitmap.
    function automatic rsp_t predict_pool_reply(input req_t req);
        rsp_t        rsp;
        logic [31:0] limit;
        logic [31:0] offset;
        int          word_idx;
        int          bit_idx;
        logic        scanned;
        limit         = live_ids();
        rsp.result_id = req.target_id;
        rsp.is_used   = 1'b0;
        rsp.status    = ST_OK;
        scanned       = 1'b0;
        if (req.cmd == CMD_ALLOC)
        begin
            rsp.result_id = '0;
            rsp.status    = ST_FULL;
            // First word that is not full decides: its lowest clear bit is
            // taken only if it lies below the count, otherwise the pool is full.
            for (word_idx = 0; word_idx < MAP_WORDS && !scanned; word_idx++)
            begin
                if (shadow_map[word_idx] != WORD_FULL)
                begin
                    scanned = 1'b1;
                    bit_idx = 0;
                    while (bit_idx < BITS_PER_WORD && shadow_map[word_idx][bit_idx])
                        bit_idx++;
                    offset = 32'(word_idx * BITS_PER_WORD + bit_idx);
                    if (offset < limit)
                    begin
                        shadow_map[word_idx][bit_idx] = 1'b1;
                        rsp.result_id = shadow_base + offset;
                        rsp.status    = ST_OK;
                    end
                end
            end
        end
        else if (req.cmd == CMD_FREE || req.cmd == CMD_CHECK)
        begin
            // Offset wraps modulo 2^32, so IDs below base land far out of range
            offset = req.target_id - shadow_base;
            if (offset >= limit)
                rsp.status = ST_RANGE;
            else if (req.cmd == CMD_FREE)
                shadow_map[offset / BITS_PER_WORD][offset % BITS_PER_WORD] = 1'b0;
            else
                rsp.is_used = shadow_map[offset / BITS_PER_WORD][offset % BITS_PER_WORD];
        end
        else
        begin
            rsp.status = ST_RANGE;
        end
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Sample in the active region of the edge, so pre-edge values are seen;
    // the reply must be taken in its strobe cycle since it cannot be held.
    always @(posedge clk)
    begin : reply_check
        rsp_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_replies.size() == 0)
            begin
                report_mismatch($sformatf("reply with no request pending, result_id %h",
                                          response.result_id));
            end
            else
            begin
                want = pending_replies.pop_front();
                if (response.result_id !== want.result_id)
                    report_mismatch($sformatf("result_id %h, predicted %h",
                                              response.result_id, want.result_id));
                if (response.is_used !== want.is_used)
                    report_mismatch($sformatf("is_used %b, predicted %b (id %h)",
                                              response.is_used, want.is_used,
                                              want.result_id));
                if (response.status !== want.status)
                    report_mismatch($sformatf("status %0d, predicted %0d (id %h)",
                                              response.status, want.status,
                                              want.result_id));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Send one request: hold start until the block takes it, predict the
    // reply, then idle for a random gap. With no gap, start stays high so the
    // next request can be taken in the cycle the current reply comes out.
    task automatic send_request(input logic [1:0] cmd, input logic [31:0] id);
        req_t req;
        rsp_t rsp;
        int   roll;
        int   gap;
        req.cmd       = cmd;
        req.target_id = id;
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        rsp = predict_pool_reply(req);
        pending_replies.push_back(rsp);
        last_status = rsp.status;
        sent_count++;
        case (cmd)
            CMD_ALLOC: alloc_count++;
            CMD_FREE:  free_count++;
            CMD_CHECK: check_count++;
            default:   other_count++;
        endcase
        if (rsp.status == ST_FULL)
            full_count++;
        if (rsp.status == ST_RANGE)
            range_count++;
        // Now and then switch to a stretch of back-to-back requests
        if (sent_count % 64 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55)
            gap = 0;
        else if (roll < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(4, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and wait until every predicted reply has come back.
    task automatic wait_idle();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (pending_replies.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        // Every request yields a reply, so a short pause covers the handoff
        repeat (4) @(posedge clk);
    endtask

    // Program both registers back to back while the block is idle. The
    // count word may carry junk above bit 10; the block keeps 11 bits.
    task automatic set_pool(input logic [31:0] base, input logic [31:0] count_word);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BASE_ID;
        cfg_wdata <= base;
        @(posedge clk);
        cfg_index <= CFG_ID_COUNT;
        cfg_wdata <= count_word;
        @(posedge clk);
        cfg_we       <= 1'b0;
        shadow_base  = base;
        shadow_count = count_word[CNT_W-1:0];
    endtask

    // One random request: allocate, free or check of an ID in range, or else
    // noise (free or check of any 32-bit ID, or the unknown command).
    task automatic send_random(input int alloc_pct, input int free_pct, input int check_pct);
        int          roll;
        logic [31:0] in_range;
        roll = $urandom_range(0, 99);
        if (live_ids() == 0)
            in_range = $urandom();
        else
            in_range = shadow_base + $urandom_range(0, live_ids() - 1);
        if (roll < alloc_pct)
            send_request(CMD_ALLOC, $urandom());
        else if (roll < alloc_pct + free_pct)
            send_request(CMD_FREE, in_range);
        else if (roll < alloc_pct + free_pct + check_pct)
            send_request(CMD_CHECK, in_range);
        else
            send_request(2'($urandom_range(CMD_FREE, CMD_UNKNOWN)), $urandom());
    endtask

    task automatic churn_pool(input logic [31:0] base, input logic [31:0] count_word);
        set_pool(base, count_word);
        repeat (40) send_random(40, 35, 15);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: allocate, free, check, first-fit reuse, range edges.
    task automatic test_basic_ops();
        send_request(CMD_CHECK,   32'd0);          // nothing used after reset
        send_request(CMD_ALLOC,   32'hFFFF_FFFF);  // target ignored
        send_request(CMD_ALLOC,   32'd0);
        send_request(CMD_CHECK,   32'd1);
        send_request(CMD_FREE,    32'd0);
        send_request(CMD_FREE,    32'd0);          // free of an ID already free
        send_request(CMD_ALLOC,   32'd0);          // lowest hole is reused
        send_request(CMD_CHECK,   32'd1024);       // one past the last ID
        send_request(CMD_FREE,    32'hFFFF_FFFF);
        send_request(CMD_UNKNOWN, 32'hFFFF_FFFF);
    endtask

    // A count of zero: allocate is full, free and check are out of range.
    task automatic test_zero_count();
        set_pool(32'd0, 32'd0);
        send_request(CMD_ALLOC, 32'd0);
        send_request(CMD_CHECK, 32'd0);
        send_request(CMD_FREE,  32'd0);
    endtask

    // Three IDs starting at the top of the 32-bit space: IDs wrap to zero,
    // and the clear bit past the count is never handed out.
    task automatic test_wrapped_pool();
        set_pool(32'hFFFF_FFFF, 32'd3);
        send_request(CMD_ALLOC, 32'd0);            // offsets 0 and 1 are held
        send_request(CMD_ALLOC, 32'd0);            // next clear bit is past count
        send_request(CMD_CHECK, 32'hFFFF_FFFF);
        send_request(CMD_CHECK, 32'd2);            // offset 3, out of range
        send_request(CMD_FREE,  32'd0);
        send_request(CMD_ALLOC, 32'd0);
    endtask

    // Largest count register value behaves as the full capacity.
    task automatic test_capacity_clamp();
        set_pool(32'h8000_0000, 32'd2047);
        send_request(CMD_CHECK, 32'h8000_03FF);
        send_request(CMD_CHECK, 32'h8000_0400);
        send_request(CMD_FREE,  32'h7FFF_FFFF);
    endtask

    // Allocate-heavy traffic over the whole capacity until the pool runs
    // dry, so the scan reaches the last word; keep going a little after.
    task automatic test_fill_pool();
        int after_full;
        int sent;
        after_full = 0;
        sent       = 0;
        set_pool($urandom(), {21'($urandom()), 11'(POOL_CAPACITY)});
        while (after_full < 30 && sent < 1400)
        begin
            send_random(96, 1, 2);
            if (after_full > 0 || last_status == ST_FULL)
                after_full++;
            sent++;
        end
    endtask

    // Mixed traffic over a nearly full bitmap with assorted pool shapes.
    task automatic test_pool_churn();
        churn_pool($urandom(), 32'd1);
        churn_pool(32'hFFFF_FFFA, 32'd13);
        churn_pool($urandom(), 32'($urandom_range(2, 64)));
        churn_pool(32'd0, 32'(POOL_CAPACITY));
        churn_pool($urandom(), {21'($urandom()), 11'd1500});
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        foreach (shadow_map[i])
            shadow_map[i] = '0;
        shadow_base  = '0;
        shadow_count = CNT_W'(1024);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_zero_count();
        test_wrapped_pool();
        test_capacity_clamp();
        test_fill_pool();
        test_pool_churn();

        wait_idle();
        repeat (20) @(posedge clk);
        if (pending_replies.size() != 0)
            report_mismatch($sformatf("%0d replies never arrived", pending_replies.size()));

        $display("Sent %0d requests: %0d allocate, %0d free, %0d check, %0d unknown",
                 sent_count, alloc_count, free_count, check_count, other_count);
        $display("Saw %0d pool-full and %0d out-of-range replies; %0d mismatches",
                 full_count, range_count, error_count);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hang guard: several times the slowest legal run
    initial
    begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
